### rtl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ICP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ICP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/icp_pkg.sv
`timescale 1ns / 1ps
package icp_pkg;
	localparam int MAX_NODES = 1024;
	localparam int TOP_COUNT = 3;
	localparam int ID_W = 10;
	localparam int SZ_W = 11;
	localparam int SQ_W = 21;
	localparam int MEAN_W = 26;
	localparam int EDGE_W = 32;
	localparam int DIV_W = SQ_W + 16;
	localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

	// Kind of cluster update caused by one request.
	localparam logic [1:0] KIND_NONE = 2'd0, KIND_NEW = 2'd1, KIND_JOIN = 2'd2,
		KIND_MERGE = 2'd3;

	// Histogram operations: which size is removed or added.
	localparam logic [3:0] HS_ADD_NEW = 4'd0, HS_REM_JOIN = 4'd1, HS_ADD_JOIN = 4'd2,
		HS_REM_A = 4'd3, HS_REM_B = 4'd4, HS_ADD_AB = 4'd5, HS_NONE = 4'd15;

	// Controller commands to the datapath.
	typedef struct packed {
		logic clr_step;    // clearing pass: write entry cnt as reset value
		logic load;        // capture request, read label of a
		logic rd_b;        // read label of b
		logic rd_sz;       // read cluster sizes
		logic upd;         // apply cluster update (non-merge part)
		logic relabel;     // one relabel sweep step
		logic merge_fin;   // finish merge sizes
		logic hrm1;        // histogram read step: latch index and direction, update square sum
		logic hist_wr;     // histogram write
		logic scan_step;   // scan histogram step
		logic div_start;
		logic div_step;
		logic out_load;
	} icp_cmd_t;

	typedef struct packed {
		logic       cnt_last;
		logic       top_full;
		logic       div_last;
		logic [1:0] kind;
	} icp_sts_t;
endpackage

### rtl/incremental_cluster_percolation.sv
`timescale 1ns / 1ps
// Channel    Valid       Stall       Payload
// request    in_valid    in_stall    node_a, node_b
// result     out_valid   out_stall   largest_size .. seen_edges
//
// After reset a clearing pass walks all 1025 store entries, one per cycle,
// and no request is taken until it ends.
// The node label memory sweep for a relabel (merge only) and the histogram scan dominate
// a request, followed by a restoring divide for the mean.
// One request is processed at a time; the next request may be taken while the
// result waits in its register, and a new result is held until the old one leaves.
module incremental_cluster_percolation import icp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ID_W-1:0]   node_a,
	input  logic [ID_W-1:0]   node_b,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SZ_W-1:0]   largest_size,
	output logic [SZ_W-1:0]   second_size,
	output logic [SZ_W-1:0]   third_size,
	output logic [SQ_W-1:0]   reduced_square_sum,
	output logic [MEAN_W-1:0] reduced_mean_size,
	output logic [SZ_W-1:0]   seen_nodes,
	output logic [EDGE_W-1:0] seen_edges
);
	icp_cmd_t cmd;
	icp_sts_t sts;
	logic [3:0] hsel;
	logic cnt_clr;

	icp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .cmd, .hsel, .cnt_clr
	);

	icp_datapath u_dp (
		.clk, .arst_n, .in_a(node_a), .in_b(node_b), .cmd, .hsel, .cnt_clr, .sts,
		.o_largest(largest_size), .o_second(second_size), .o_third(third_size),
		.o_reduced(reduced_square_sum), .o_mean(reduced_mean_size),
		.o_nodes(seen_nodes), .o_edges(seen_edges)
	);
endmodule

### rtl/icp_datapath.sv
`timescale 1ns / 1ps
module icp_datapath import icp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ID_W-1:0]   in_a,
	input  logic [ID_W-1:0]   in_b,
	input  icp_cmd_t          cmd,
	input  logic [3:0]        hsel,
	input  logic              cnt_clr,
	output icp_sts_t          sts,
	output logic [SZ_W-1:0]   o_largest,
	output logic [SZ_W-1:0]   o_second,
	output logic [SZ_W-1:0]   o_third,
	output logic [SQ_W-1:0]   o_reduced,
	output logic [MEAN_W-1:0] o_mean,
	output logic [SZ_W-1:0]   o_nodes,
	output logic [EDGE_W-1:0] o_edges
);
	// Memories: node labels (valid in bit 11), cluster sizes, size histogram.
	logic [SZ_W:0]   lab_mem [MAX_NODES];
	logic [SZ_W-1:0] csz_mem [MAX_NODES];
	logic [SZ_W-1:0] hst_mem [MAX_NODES+1];

	logic [ID_W-1:0] a_q, b_q;
	logic [SZ_W:0]   la_q, lb_q;
	logic [SZ_W-1:0] sa_q, sb_q;
	logic [SZ_W:0]   cnt_q;
	logic [SZ_W:0]   rd_lab_q;
	logic [SZ_W-1:0] rd_hst_q;
	logic [SZ_W-1:0] next_q, nodes_q;
	logic [SQ_W-1:0] sq_q;
	logic [EDGE_W-1:0] edges_q;
	logic [SZ_W-1:0] top_q [TOP_COUNT];
	logic [1:0]      k_q;
	logic [SZ_W-1:0] keep_q, drop_q;
	logic [SZ_W-1:0] hidx_q;
	logic            hinc_q;
	logic [SQ_W-1:0] red_q;
	logic [DIV_W-1:0] rem_q, quo_q;
	logic [5:0]      dcnt_q;

	// Update classification computed after sizes are read.
	logic ka, kb;
	logic [SZ_W-1:0] ca, cb;
	assign ka = la_q[SZ_W];
	assign kb = lb_q[SZ_W];
	assign ca = la_q[SZ_W-1:0];
	assign cb = lb_q[SZ_W-1:0];

	logic [1:0] kind;
	always_comb begin
		if (!ka && !kb) kind = (next_q[SZ_W-1]) ? KIND_NONE : KIND_NEW;
		else if (ka != kb) kind = KIND_JOIN;
		else kind = (ca == cb) ? KIND_NONE : KIND_MERGE;
	end
	logic a_keep;
	assign a_keep = (sa_q >= sb_q);
	logic [SZ_W-1:0] new_sz, join_c, join_old;
	assign new_sz = (a_q == b_q) ? SZ_W'(1) : SZ_W'(2);
	assign join_c = ka ? ca : cb;
	assign join_old = ka ? sa_q : sb_q;

	// Histogram ops: hsel selects which size is removed or added.
	logic [SZ_W-1:0] hsize;
	logic            hadd;
	always_comb begin
		case (hsel)
			HS_ADD_NEW: begin hsize = new_sz; hadd = 1'b1; end
			HS_REM_JOIN: begin hsize = join_old; hadd = 1'b0; end
			HS_ADD_JOIN: begin hsize = join_old + SZ_W'(1); hadd = 1'b1; end
			HS_REM_A: begin hsize = sa_q; hadd = 1'b0; end
			HS_REM_B: begin hsize = sb_q; hadd = 1'b0; end
			HS_ADD_AB: begin hsize = sa_q + sb_q; hadd = 1'b1; end
			default: begin hsize = '0; hadd = 1'b1; end
		endcase
	end
	logic [SQ_W-1:0] sq_term;
	logic [2*SZ_W-1:0] prod;
	assign prod = hsize * hsize;
	assign sq_term = prod[SQ_W-1:0];

	assign sts.cnt_last = (cnt_q == (SZ_W+1)'(MAX_NODES));
	assign sts.top_full = (k_q == 2'(TOP_COUNT));
	assign sts.div_last = (dcnt_q == 6'(DIV_W - 1));
	assign sts.kind = kind;

	logic [SZ_W-1:0] scan_idx;
	assign scan_idx = SZ_W'(MAX_NODES) - cnt_q[SZ_W-1:0];
	// Free places left in the top list.
	logic [SZ_W-1:0] room;
	assign room = SZ_W'(TOP_COUNT) - SZ_W'(k_q);

	// Memory ports.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			lab_mem[cnt_q[ID_W-1:0]] <= '0;
			csz_mem[cnt_q[ID_W-1:0]] <= '0;
			hst_mem[cnt_q[SZ_W-1:0]] <= '0;
		end else if (cmd.upd) begin
			if (kind == KIND_NEW) begin
				lab_mem[a_q] <= {1'b1, next_q};
				lab_mem[b_q] <= {1'b1, next_q};
				csz_mem[next_q[ID_W-1:0]] <= new_sz;
			end else if (kind == KIND_JOIN) begin
				lab_mem[ka ? b_q : a_q] <= {1'b1, join_c};
				csz_mem[join_c[ID_W-1:0]] <= join_old + SZ_W'(1);
			end
		end else if (cmd.relabel) begin
			// Read data is registered and belongs to the previous sweep address, so the first step only reads.
			if (cnt_q != '0 && rd_lab_q[SZ_W] && rd_lab_q[SZ_W-1:0] == drop_q)
				lab_mem[cnt_q[ID_W-1:0] - ID_W'(1)] <= {1'b1, keep_q};
		end else if (cmd.merge_fin) begin
			csz_mem[keep_q[ID_W-1:0]] <= sa_q + sb_q;
			csz_mem[drop_q[ID_W-1:0]] <= '0;
		end
		if (cmd.hist_wr && !cmd.clr_step)
			hst_mem[hidx_q] <= hinc_q ? rd_hst_q + SZ_W'(1)
				: ((rd_hst_q != '0) ? rd_hst_q - SZ_W'(1) : rd_hst_q);
		if (cmd.load) la_q <= lab_mem[in_a];
		if (cmd.rd_b) lb_q <= lab_mem[b_q];
		if (cmd.rd_sz) begin
			sa_q <= csz_mem[ca[ID_W-1:0]];
			sb_q <= csz_mem[cb[ID_W-1:0]];
		end
		rd_lab_q <= lab_mem[cnt_q[ID_W-1:0]];
		rd_hst_q <= cmd.scan_step ? hst_mem[scan_idx] : hst_mem[hsize];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; next_q <= '0; nodes_q <= '0; sq_q <= '0; edges_q <= '0;
			k_q <= '0; dcnt_q <= '0;
			for (int i = 0; i < TOP_COUNT; i++) top_q[i] <= '0;
		end else begin
			if (cnt_clr) cnt_q <= '0;
			else if (cmd.clr_step || cmd.relabel || cmd.scan_step) cnt_q <= cnt_q + 1'b1;
			if (cmd.load) begin
				a_q <= in_a; b_q <= in_b;
				if (edges_q != '1) edges_q <= edges_q + 1'b1;
				k_q <= '0;
				for (int i = 0; i < TOP_COUNT; i++) top_q[i] <= '0;
			end
			if (cmd.rd_sz) begin
				keep_q <= (sa_q >= sb_q) ? ca : cb;
			end
			if (cmd.upd) begin
				keep_q <= a_keep ? ca : cb;
				drop_q <= a_keep ? cb : ca;
				if (kind == KIND_NEW) begin
					next_q <= next_q + 1'b1;
					nodes_q <= nodes_q + new_sz;
				end else if (kind == KIND_JOIN) nodes_q <= nodes_q + 1'b1;
			end
			if (cmd.hrm1) begin
				hidx_q <= hsize; hinc_q <= hadd;
				sq_q <= hadd ? sq_q + sq_term : sq_q - sq_term;
			end
			// Histogram scan, read data arrives in the cycle after the address. All
			// clusters of one size fill the free places of the top list at once.
			if (cmd.scan_step && cnt_q != '0 && !sts.top_full) begin
				if (rd_hst_q != '0) begin
					for (int i = 0; i < TOP_COUNT; i++)
						if (SZ_W'(i) >= SZ_W'(k_q) && SZ_W'(i) - SZ_W'(k_q) < rd_hst_q)
							top_q[i] <= scan_idx + SZ_W'(1);
					k_q <= (rd_hst_q >= room) ? 2'(TOP_COUNT) : k_q + rd_hst_q[1:0];
				end
			end
			if (cmd.div_start) dcnt_q <= '0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + 1'b1;
		end
	end

	// Restoring divider, one quotient bit per cycle.
	logic [2*SZ_W-1:0] top_sq;
	logic [SQ_W-1:0]   red_d;
	assign top_sq = top_q[0] * top_q[0];
	assign red_d = sq_q - top_sq[SQ_W-1:0];
	logic [DIV_W:0] trial;
	assign trial = {rem_q, quo_q[DIV_W-1]} - {{(DIV_W-SZ_W+1){1'b0}}, nodes_q};
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			red_q <= red_d;
			quo_q <= {red_d, 16'd0};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			o_largest <= top_q[0];
			o_second <= top_q[1];
			o_third <= top_q[2];
			o_reduced <= red_q;
			o_nodes <= nodes_q;
			o_edges <= edges_q;
			if (nodes_q == '0) o_mean <= '0;
			else if (quo_q > DIV_W'(MEAN_MAX)) o_mean <= MEAN_MAX;
			else o_mean <= quo_q[MEAN_W-1:0];
		end
	end
endmodule

### rtl/icp_ctrl.sv
`timescale 1ns / 1ps
module icp_ctrl import icp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  icp_sts_t sts,
	output icp_cmd_t cmd,
	output logic [3:0] hsel,
	output logic     cnt_clr
);
	localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_RDB = 5'd2, S_RDSZ = 5'd3,
		S_CLS = 5'd4, S_H1R = 5'd5, S_H1W = 5'd6, S_H2R = 5'd7, S_H2W = 5'd8,
		S_H3R = 5'd9, S_H3W = 5'd10, S_REL = 5'd11, S_MFIN = 5'd12,
		S_SCAN = 5'd13, S_DIV0 = 5'd14, S_DIV = 5'd15, S_OUT = 5'd16, S_WAIT = 5'd17,
		S_H0 = 5'd18;
	logic [4:0] st_q;
	logic [1:0] kind_q;
	logic       ov_q;
	assign out_valid = ov_q;
	assign in_stall = !(st_q == S_IDLE);
	always_comb begin
		cmd = '0; hsel = HS_NONE; cnt_clr = 1'b0;
		case (st_q)
			S_CLR: cmd.clr_step = 1'b1;
			S_IDLE: cmd.load = in_valid;
			S_RDB: cmd.rd_b = 1'b1;
			S_RDSZ: cmd.rd_sz = 1'b1;
			S_CLS: cmd.upd = 1'b1;
			S_H1R, S_H1W: hsel = (kind_q == KIND_NEW) ? HS_ADD_NEW
				: (kind_q == KIND_JOIN ? HS_REM_JOIN : HS_REM_A);
			S_H2R, S_H2W: hsel = (kind_q == KIND_JOIN) ? HS_ADD_JOIN : HS_REM_B;
			S_H3R, S_H3W: hsel = HS_ADD_AB;
			S_REL: cmd.relabel = 1'b1;
			S_MFIN: begin cmd.merge_fin = (kind_q == KIND_MERGE); cnt_clr = 1'b1; end
			S_SCAN: cmd.scan_step = 1'b1;
			S_DIV0: cmd.div_start = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_OUT: cmd.out_load = 1'b1;
			default: ;
		endcase
		if (st_q == S_H1R || st_q == S_H2R || st_q == S_H3R) cmd.hrm1 = 1'b1;
		if (st_q == S_H1W || st_q == S_H2W || st_q == S_H3W) cmd.hist_wr = 1'b1;
		if (st_q == S_H0) cnt_clr = 1'b1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; kind_q <= KIND_NONE; ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			case (st_q)
				S_CLR: if (sts.cnt_last) st_q <= S_H0;
				S_H0: st_q <= S_IDLE;
				S_IDLE: if (in_valid) st_q <= S_RDB;
				S_RDB: st_q <= S_RDSZ;
				S_RDSZ: st_q <= S_CLS;
				S_CLS: begin
					kind_q <= sts.kind;
					st_q <= (sts.kind == KIND_NONE) ? S_MFIN : S_H1R;
				end
				S_H1R: st_q <= S_H1W;
				S_H1W: st_q <= (kind_q == KIND_NEW) ? S_MFIN : S_H2R;
				S_H2R: st_q <= S_H2W;
				S_H2W: st_q <= (kind_q == KIND_JOIN) ? S_MFIN : S_REL;
				S_REL: if (sts.cnt_last) st_q <= S_H3R;
				S_H3R: st_q <= S_H3W;
				S_H3W: st_q <= S_MFIN;
				S_MFIN: st_q <= S_SCAN;
				S_SCAN: if (sts.cnt_last || sts.top_full) st_q <= S_DIV0;
				S_DIV0: st_q <= S_DIV;
				S_DIV: if (sts.div_last) st_q <= S_WAIT;
				S_WAIT: if (!ov_q || !out_stall) st_q <= S_OUT;
				S_OUT: begin ov_q <= 1'b1; st_q <= S_H0; end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/icp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module icp_checker import icp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [EDGE_W-1:0] seen_edges
);
	logic out_held;
	assign out_held = out_valid && out_stall;

	`ICP_ASSERT_NEXT(a_out_keep, clk, arst_n, out_held, $stable(seen_edges), "payload moved")
	`ICP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, out_valid, "result dropped")
	`ICP_ASSERT_NEXT(a_stall_after, clk, arst_n, in_valid && !in_stall, in_stall, "overlap")
endmodule

bind incremental_cluster_percolation icp_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .seen_edges
);
